>>> hdl/lzd_pkg.sv
// Shared types and constants of the LZSS bitstream decoder.
// Used by the controller, the datapath and the top level.
package lzd_pkg;

	localparam int DEF_HIST_AW     = 8;
	localparam int DEF_LENGTH_BITS = 4;
	localparam int DEF_COPY_MIN    = 3;
	localparam int LIT_TOKEN_BITS  = 9;
	localparam logic [15:0] CAP_RESET = 16'hFFFF;

	typedef enum logic [1:0] {
		STAT_RUNNING  = 2'd0,
		STAT_FINISHED = 2'd1,
		STAT_CORRUPT  = 2'd2,
		STAT_TOO_BIG  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_LEN_LO = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_TOKENS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_BIT, ST_LIT, ST_REF, ST_COPY_RD, ST_COPY_WR, ST_FINISH, ST_STATUS
	} state_t;

	typedef struct packed {
		logic accept;
		logic bit_step;
		logic emit_lit;
		logic mark_large;
		logic ref_check;
		logic copy_rd;
		logic copy_wr;
		logic finish;
		logic status_emit;
	} cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   lit_done;
		logic   ref_done;
		logic   last_bit;
		logic   bits_empty;
		logic   cap_hit;
		logic   off_bad;
		logic   run_last;
		logic   stop;
		logic   out_free;
	} sts_t;

endpackage

>>> hdl/lzd_if.sv
// Valid/ready channel interfaces: compressed byte requests in, decoded results out.
// Depends on nothing.
interface lzd_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       stream_end;
	modport source (output valid, in_byte, stream_end, input ready);
	modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface lzd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        run_last;
	logic [1:0]  status;
	logic [15:0] total_out;
	modport source (output valid, out_byte, byte_valid, run_last, status, total_out,
		input ready);
	modport sink   (input valid, out_byte, byte_valid, run_last, status, total_out,
		output ready);
endinterface

>>> hdl/lzd_ctrl.sv
// Controller state machine of the LZSS decoder: sequences bits, copies and status.
// Depends on lzd_pkg.
module lzd_ctrl import lzd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   code_valid,
	output logic   code_ready,
	input  sts_t   sts,
	output cmd_t   cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (code_valid) begin
					state_n = (sts.phase == PH_TOKENS) ? ST_BIT : ST_STATUS;
				end
			end
			ST_BIT: begin
				if (sts.lit_done)      state_n = ST_LIT;
				else if (sts.ref_done) state_n = ST_REF;
				else if (sts.last_bit) state_n = ST_STATUS;
			end
			ST_LIT: begin
				if (sts.cap_hit || sts.out_free) state_n = ST_FINISH;
			end
			ST_REF:     state_n = sts.off_bad ? ST_FINISH : ST_COPY_RD;
			ST_COPY_RD: state_n = sts.cap_hit ? ST_FINISH : ST_COPY_WR;
			ST_COPY_WR: begin
				if (sts.out_free) state_n = sts.run_last ? ST_FINISH : ST_COPY_RD;
			end
			ST_FINISH:  state_n = (sts.stop || sts.bits_empty) ? ST_STATUS : ST_BIT;
			ST_STATUS: begin
				if (sts.out_free) state_n = ST_IDLE;
			end
			default:    state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		code_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				code_ready = 1'b1;
				cmd.accept = code_valid;
			end
			ST_BIT:  cmd.bit_step = 1'b1;
			ST_LIT: begin
				cmd.mark_large = sts.cap_hit;
				cmd.emit_lit   = !sts.cap_hit && sts.out_free;
			end
			ST_REF:  cmd.ref_check = 1'b1;
			ST_COPY_RD: begin
				cmd.copy_rd    = 1'b1;
				cmd.mark_large = sts.cap_hit;
			end
			ST_COPY_WR:  cmd.copy_wr = sts.out_free;
			ST_FINISH:   cmd.finish = 1'b1;
			ST_STATUS:   cmd.status_emit = sts.out_free;
			default: ;
		endcase
	end

	a_copy_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY_WR && !sts.out_free) |=> state_q == ST_COPY_WR)
		else $error("copy advanced without output slot");
	a_tok_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && sts.phase == PH_TOKENS) |=> state_q == ST_BIT)
		else $error("token byte not decoded");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.bit_step, cmd.emit_lit, cmd.ref_check, cmd.copy_wr,
			cmd.finish, cmd.status_emit}))
		else $error("conflicting commands");

endmodule

>>> hdl/lzd_datapath.sv
// Datapath of the LZSS decoder: header, token shifter, history ring, counters,
// capacity register and output register. Depends on lzd_pkg.
module lzd_datapath import lzd_pkg::*; #(
	parameter int HIST_AW     = DEF_HIST_AW,
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int COPY_MIN    = DEF_COPY_MIN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic [1:0]  status,
	output logic [15:0] total_out
);

	localparam int TOKW  = 1 + HIST_AW + LENGTH_BITS;
	localparam int CNTW  = $clog2(TOKW + 1);
	localparam int LENW  = LENGTH_BITS + 1;
	localparam int DEPTH = 1 << HIST_AW;

	logic [15:0]            cap_q, orig_q, prod_q;
	phase_t                 phase_q;
	status_t                outcome_q;
	logic [TOKW-1:0]        tok_q, tok_n;
	logic [CNTW-1:0]        tcnt_q, tcnt_n;
	logic                   first_q, first_n;
	logic [7:0]             byte_q;
	logic                   end_q;
	logic [3:0]             bits_q;
	logic [LENW-1:0]        len_q;
	logic [7:0]             rd_q;
	logic [7:0]             mem [DEPTH];
	logic [HIST_AW-1:0]     off_field, rd_addr;
	logic [HIST_AW:0]       offset;
	logic [15:0]            orig_full;
	logic                   out_valid_q, out_free, emit;
	logic [7:0]             emit_byte;
	status_t                end_status;
	logic [7:0]             out_byte_q;
	logic                   byte_valid_q;
	logic                   run_last_q;
	logic [1:0]             status_q;
	logic [15:0]            total_out_q;

	assign tok_n     = {tok_q[TOKW-2:0], byte_q[7]};
	assign tcnt_n    = tcnt_q + CNTW'(1);
	assign first_n   = (tcnt_q == '0) ? byte_q[7] : first_q;
	assign off_field = tok_q[LENGTH_BITS +: HIST_AW];
	assign offset    = {1'b0, off_field} + (HIST_AW+1)'(1);
	assign rd_addr   = prod_q[HIST_AW-1:0] - off_field - HIST_AW'(1);
	assign orig_full = {in_byte, orig_q[7:0]};
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = cmd.emit_lit || cmd.copy_wr;
	assign emit_byte = cmd.emit_lit ? tok_q[7:0] : rd_q;
	assign end_status = (end_q && outcome_q == STAT_RUNNING) ? STAT_CORRUPT : outcome_q;

	always_comb begin
		sts.phase      = phase_q;
		sts.lit_done   = first_n && tcnt_n == CNTW'(LIT_TOKEN_BITS);
		sts.ref_done   = !first_n && tcnt_n == CNTW'(TOKW);
		sts.last_bit   = bits_q == 4'd1;
		sts.bits_empty = bits_q == 4'd0;
		sts.cap_hit    = prod_q >= cap_q;
		sts.off_bad    = 16'(offset) > prod_q;
		sts.run_last   = len_q == LENW'(1);
		sts.stop       = outcome_q != STAT_RUNNING || prod_q >= orig_q;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q     <= CAP_RESET;
			phase_q   <= PH_LEN_LO;
			orig_q    <= '0;
			prod_q    <= '0;
			outcome_q <= STAT_RUNNING;
			tok_q     <= '0;
			tcnt_q    <= '0;
			first_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (cmd.accept) begin
				case (phase_q)
					PH_LEN_LO: begin
						orig_q  <= {8'd0, in_byte};
						phase_q <= PH_LEN_HI;
					end
					PH_LEN_HI: begin
						orig_q <= orig_full;
						if (orig_full == '0) begin
							outcome_q <= STAT_FINISHED;
							phase_q   <= PH_DONE;
						end else if (orig_full > cap_q) begin
							outcome_q <= STAT_TOO_BIG;
							phase_q   <= PH_DONE;
						end else begin
							phase_q <= PH_TOKENS;
						end
					end
					default: ;
				endcase
			end
			if (cmd.bit_step) begin
				tok_q   <= tok_n;
				tcnt_q  <= tcnt_n;
				first_q <= first_n;
			end
			if (cmd.mark_large) outcome_q <= STAT_TOO_BIG;
			if (cmd.ref_check && sts.off_bad) outcome_q <= STAT_CORRUPT;
			if (emit) prod_q <= prod_q + 16'd1;
			if (cmd.finish) begin
				tok_q   <= '0;
				tcnt_q  <= '0;
				first_q <= 1'b0;
				if (outcome_q == STAT_RUNNING && prod_q >= orig_q) outcome_q <= STAT_FINISHED;
				if (sts.stop) phase_q <= PH_DONE;
			end
			// end of stream: drop all per-stream state after the status
			if (cmd.status_emit && end_q) begin
				phase_q   <= PH_LEN_LO;
				orig_q    <= '0;
				prod_q    <= '0;
				outcome_q <= STAT_RUNNING;
				tok_q     <= '0;
				tcnt_q    <= '0;
				first_q   <= 1'b0;
			end
			if (emit || cmd.status_emit) out_valid_q <= 1'b1;
			else if (out_ready)          out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_byte;
			end_q  <= stream_end;
			bits_q <= 4'd8;
		end
		if (cmd.bit_step) begin
			byte_q <= {byte_q[6:0], 1'b0};
			bits_q <= bits_q - 4'd1;
		end
		if (cmd.ref_check) len_q <= LENW'(tok_q[LENGTH_BITS-1:0]) + LENW'(COPY_MIN);
		if (cmd.copy_wr)   len_q <= len_q - LENW'(1);
		if (cmd.copy_rd)   rd_q <= mem[rd_addr];
		if (emit)          mem[prod_q[HIST_AW-1:0]] <= emit_byte;
		if (emit) begin
			out_byte_q   <= emit_byte;
			byte_valid_q <= 1'b1;
			run_last_q   <= 1'b0;
			status_q     <= STAT_RUNNING;
			total_out_q  <= prod_q + 16'd1;
		end else if (cmd.status_emit) begin
			out_byte_q   <= 8'd0;
			byte_valid_q <= 1'b0;
			run_last_q   <= 1'b1;
			status_q     <= end_status;
			total_out_q  <= prod_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign byte_valid = byte_valid_q;
	assign run_last   = run_last_q;
	assign status     = status_q;
	assign total_out  = total_out_q;

	a_stat_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.status_emit |=> out_valid_q && run_last_q && !byte_valid_q)
		else $error("status result not loaded");
	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && byte_valid_q && total_out_q == prod_q)
		else $error("data result count mismatch");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(emit || cmd.status_emit) |-> out_free)
		else $error("output register overwritten");

endmodule

>>> hdl/lzss_bitstream_decoder.sv
// Top level of the LZSS bitstream decoder: controller plus datapath.
// Depends on lzd_pkg, lzd_if, lzd_ctrl and lzd_datapath.
//
//  channel  | direction | carries
//  code     | sink      | in_byte, stream_end (one compressed byte per request)
//  result   | source    | out_byte, byte_valid, run_last, status, total_out
//  cfg_*    | write     | out_capacity
//
// A header byte or an ignored byte passes through accept, then status result.
// A token byte: accept and bit steps, plus emit and finish per literal token,
// check and finish per back reference, history read then write per copied byte.
// Results leave through one output register; a stall there holds the sequencer.
// Reset clears all control state at once; the history ring needs no clearing.
module lzss_bitstream_decoder import lzd_pkg::*; #(
	parameter int HIST_AW     = DEF_HIST_AW,
	parameter int LENGTH_BITS = DEF_LENGTH_BITS,
	parameter int COPY_MIN    = DEF_COPY_MIN
) (
	input  logic          clk,
	input  logic          arst_n,
	lzd_code_if.sink      code,
	lzd_result_if.source  result,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	lzd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code.valid),
		.code_ready (code.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lzd_datapath #(
		.HIST_AW     (HIST_AW),
		.LENGTH_BITS (LENGTH_BITS),
		.COPY_MIN    (COPY_MIN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_byte    (code.in_byte),
		.stream_end (code.stream_end),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_byte   (result.out_byte),
		.byte_valid (result.byte_valid),
		.run_last   (result.run_last),
		.status     (result.status),
		.total_out  (result.total_out)
	);

endmodule
